FILE: hdl/keypad_four_function_calculator_top_macros.svh
// assertion macros for the keypad calculator
`ifndef KEYPAD_FOUR_FUNCTION_CALCULATOR_TOP_MACROS_SVH
`define KEYPAD_FOUR_FUNCTION_CALCULATOR_TOP_MACROS_SVH

// checked on every clock edge outside reset
`define KFC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define KFC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/kfc_pkg.sv
// types and constants shared by the keypad calculator modules
`timescale 1ns / 1ps

package kfc_pkg;

    typedef enum logic [2:0] {
        CTL_INIT,
        CTL_CLEAR,
        CTL_ENTRY1,
        CTL_OPER,
        CTL_ENTRY2,
        CTL_EVAL,
        CTL_SHOW,
        CTL_WAIT
    } ctl_state_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_UNDER,
        ERR_OVER,
        ERR_DIV0
    } err_t;

    typedef enum logic [2:0] {
        KIND_NUMBER,
        KIND_OPER,
        KIND_UNDER,
        KIND_OVER,
        KIND_DIV0
    } show_kind_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_ARITH,
        SEQ_CHK_HI,
        SEQ_CHK_LO,
        SEQ_WCHK_FIRST,
        SEQ_WCHK_SECOND,
        SEQ_EMIT
    } seq_state_t;

    typedef enum logic [2:0] {
        ARITH_ADD,
        ARITH_SUB,
        ARITH_MUL,
        ARITH_DIV,
        ARITH_MAC10
    } arith_op_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ADD,
        PH_MAC_A,
        PH_MAC_B,
        PH_MUL,
        PH_NEG_A,
        PH_NEG_B,
        PH_DIV,
        PH_NEG_Q
    } arith_phase_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
        logic [3:0] digit;
    } arith_req_t;

    localparam logic [7:0] KEY_0     = 8'd48;
    localparam logic [7:0] KEY_9     = 8'd57;
    localparam logic [7:0] KEY_MUL   = 8'd42;
    localparam logic [7:0] KEY_ADD   = 8'd43;
    localparam logic [7:0] KEY_SUB   = 8'd45;
    localparam logic [7:0] KEY_DIV   = 8'd47;
    localparam logic [7:0] KEY_EQ    = 8'd61;
    localparam logic [7:0] KEY_CLEAR = 8'd67;

    localparam logic CFG_UPPER_LIMIT = 1'b0;
    localparam logic CFG_LOWER_LIMIT = 1'b1;

    localparam logic [30:0] UPPER_RESET = 31'h7FFF_FFFF;
    localparam logic [31:0] LOWER_RESET = 32'h8000_0002;

    localparam int SHOW_WIDTH = 36;

endpackage

FILE: hdl/kfc_arith.sv
// shared iterative add, multiply, divide and digit-append unit
`timescale 1ns / 1ps

module kfc_arith #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  kfc_pkg::arith_req_t    req,
    input  logic [VALUE_WIDTH-1:0] a,
    input  logic [VALUE_WIDTH-1:0] b,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] result
);

    localparam int CW = $clog2(VALUE_WIDTH);

    kfc_pkg::arith_phase_t phase_reg, phase_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic [VALUE_WIDTH-1:0] opx_reg, opx_next;
    logic [VALUE_WIDTH-1:0] opy_reg, opy_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   neg_reg, neg_next;
    logic                   sub_reg, sub_next;
    logic [3:0]             digit_reg, digit_next;
    logic                   done_reg, done_next;

    logic [VALUE_WIDTH-1:0] add_x;
    logic [VALUE_WIDTH-1:0] add_y;
    logic                   add_sub;
    logic [VALUE_WIDTH:0]   add_sum;
    logic [VALUE_WIDTH-1:0] rem_shift;
    logic                   last_step;

    // single shared adder, carry out means no borrow on subtract
    assign add_sum = {1'b0, add_x} + {1'b0, add_y ^ {VALUE_WIDTH{add_sub}}}
                   + {{VALUE_WIDTH{1'b0}}, add_sub};
    assign rem_shift = {acc_reg[VALUE_WIDTH-2:0], opy_reg[VALUE_WIDTH-1]};
    assign last_step = (cnt_reg == CW'(VALUE_WIDTH - 1));

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        opx_next   = opx_reg;
        opy_next   = opy_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        sub_next   = sub_reg;
        digit_next = digit_reg;
        done_next  = 1'b0;
        add_x      = '0;
        add_y      = '0;
        add_sub    = 1'b0;
        case (phase_reg)
            kfc_pkg::PH_IDLE:
            begin
                if (req.start)
                begin
                    opy_next   = a;
                    opx_next   = b;
                    acc_next   = '0;
                    cnt_next   = '0;
                    neg_next   = a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1];
                    sub_next   = (req.op == kfc_pkg::ARITH_SUB);
                    digit_next = req.digit;
                    case (req.op)
                        kfc_pkg::ARITH_ADD:   phase_next = kfc_pkg::PH_ADD;
                        kfc_pkg::ARITH_SUB:   phase_next = kfc_pkg::PH_ADD;
                        kfc_pkg::ARITH_MUL:   phase_next = kfc_pkg::PH_MUL;
                        kfc_pkg::ARITH_DIV:   phase_next = kfc_pkg::PH_NEG_A;
                        kfc_pkg::ARITH_MAC10: phase_next = kfc_pkg::PH_MAC_A;
                        default:              phase_next = kfc_pkg::PH_IDLE;
                    endcase
                end
            end
            kfc_pkg::PH_ADD:
            begin
                add_x      = opy_reg;
                add_y      = opx_reg;
                add_sub    = sub_reg;
                acc_next   = add_sum[VALUE_WIDTH-1:0];
                done_next  = 1'b1;
                phase_next = kfc_pkg::PH_IDLE;
            end
            kfc_pkg::PH_MAC_A:
            begin
                // times five
                add_x      = {opy_reg[VALUE_WIDTH-3:0], 2'b00};
                add_y      = opy_reg;
                acc_next   = add_sum[VALUE_WIDTH-1:0];
                phase_next = kfc_pkg::PH_MAC_B;
            end
            kfc_pkg::PH_MAC_B:
            begin
                // times two plus the digit
                add_x      = {acc_reg[VALUE_WIDTH-2:0], 1'b0};
                add_y      = {{(VALUE_WIDTH-4){1'b0}}, digit_reg};
                acc_next   = add_sum[VALUE_WIDTH-1:0];
                done_next  = 1'b1;
                phase_next = kfc_pkg::PH_IDLE;
            end
            kfc_pkg::PH_MUL:
            begin
                add_x = acc_reg;
                add_y = opy_reg;
                if (opx_reg[0])
                begin
                    acc_next = add_sum[VALUE_WIDTH-1:0];
                end
                opy_next = {opy_reg[VALUE_WIDTH-2:0], 1'b0};
                opx_next = {1'b0, opx_reg[VALUE_WIDTH-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                begin
                    done_next  = 1'b1;
                    phase_next = kfc_pkg::PH_IDLE;
                end
            end
            kfc_pkg::PH_NEG_A:
            begin
                add_y      = opy_reg;
                add_sub    = opy_reg[VALUE_WIDTH-1];
                opy_next   = add_sum[VALUE_WIDTH-1:0];
                phase_next = kfc_pkg::PH_NEG_B;
            end
            kfc_pkg::PH_NEG_B:
            begin
                add_y      = opx_reg;
                add_sub    = opx_reg[VALUE_WIDTH-1];
                opx_next   = add_sum[VALUE_WIDTH-1:0];
                phase_next = kfc_pkg::PH_DIV;
            end
            kfc_pkg::PH_DIV:
            begin
                // restoring step, quotient bits shift in below the dividend
                add_x   = rem_shift;
                add_y   = opx_reg;
                add_sub = 1'b1;
                acc_next = add_sum[VALUE_WIDTH] ? add_sum[VALUE_WIDTH-1:0] : rem_shift;
                opy_next = {opy_reg[VALUE_WIDTH-2:0], add_sum[VALUE_WIDTH]};
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                begin
                    phase_next = kfc_pkg::PH_NEG_Q;
                end
            end
            kfc_pkg::PH_NEG_Q:
            begin
                add_y      = opy_reg;
                add_sub    = neg_reg;
                acc_next   = add_sum[VALUE_WIDTH-1:0];
                done_next  = 1'b1;
                phase_next = kfc_pkg::PH_IDLE;
            end
            default:
            begin
                phase_next = kfc_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= kfc_pkg::PH_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        opx_reg   <= opx_next;
        opy_reg   <= opy_next;
        neg_reg   <= neg_next;
        sub_reg   <= sub_next;
        digit_reg <= digit_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

FILE: hdl/keypad_four_function_calculator_top.sv
// keypad calculator top level: key state machine, sequencer and output register
//
// One input beat is one keypad tick: tuser holds the press flag, tdata the ASCII
// key. Each tick that updates the display gives one output beat: tuser holds
// the display kind (number, operator, underflow, overflow, division by zero),
// tdata the shown number in bits 35:0 and the shown operator in bits 43:36.
// Ticks that evaluate or wait give no beat.
// The input side is ready only while the sequencer is idle. Digits, add,
// subtract, multiply and divide run on the shared adder in kfc_arith.
// A finished beat sits in the output register; the next tick is taken while it
// waits, and a further beat stalls the sequencer until the receiver takes it.
// The limit registers are written through cfg_we, cfg_index and cfg_data; the
// user must write them only while the block is idle, which the block itself
// does not enforce. Reset puts the key state machine in its start state, clears
// the operands and restores the default limits.
`timescale 1ns / 1ps

`include "keypad_four_function_calculator_top_macros.svh"

module keypad_four_function_calculator_top #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // key_code
    input  logic [0:0]  s_axis_tuser,   // pressed
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // shown_value[35:0], shown_operator[43:36]
    output logic [2:0]  m_axis_tuser,   // show_kind
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int SW = kfc_pkg::SHOW_WIDTH;

    kfc_pkg::ctl_state_t ctl_reg, ctl_next;
    kfc_pkg::ctl_state_t last_reg, last_next;
    kfc_pkg::seq_state_t seq_reg, seq_next;
    kfc_pkg::err_t       err_reg, err_next;
    logic                press_reg, press_next;
    logic [VALUE_WIDTH-1:0] first_reg, first_next;
    logic [VALUE_WIDTH-1:0] second_reg, second_next;
    logic [VALUE_WIDTH-1:0] answer_reg, answer_next;
    logic [7:0]          oper_reg, oper_next;
    logic [30:0]         upper_reg;
    logic [31:0]         lower_reg;

    kfc_pkg::show_kind_t pend_kind_reg, pend_kind_next;
    logic [SW-1:0]       pend_value_reg, pend_value_next;
    logic [7:0]          pend_oper_reg, pend_oper_next;

    logic                out_valid_reg, out_valid_next;
    kfc_pkg::show_kind_t out_kind_reg, out_kind_next;
    logic [SW-1:0]       out_value_reg, out_value_next;
    logic [7:0]          out_oper_reg, out_oper_next;

    logic                in_accept;
    logic                pressed;
    logic [7:0]          key;
    logic                is_dig;
    logic                is_op;
    logic                press_edge;
    logic                chain;
    kfc_pkg::ctl_state_t trans_state;
    kfc_pkg::ctl_state_t trans_last;

    kfc_pkg::arith_req_t    arith_req;
    logic [VALUE_WIDTH-1:0] arith_a;
    logic                   arith_done;
    logic [VALUE_WIDTH-1:0] arith_result;

    logic [VALUE_WIDTH-1:0] hi_ext;
    logic [VALUE_WIDTH-1:0] lo_ext;
    logic [VALUE_WIDTH-1:0] cmp_a;
    logic [VALUE_WIDTH-1:0] cmp_b;
    logic                   cmp_lt;

    assign pressed    = s_axis_tuser[0];
    assign key        = s_axis_tdata;
    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign is_dig     = (key >= kfc_pkg::KEY_0) && (key <= kfc_pkg::KEY_9);
    assign is_op      = (key == kfc_pkg::KEY_MUL) || (key == kfc_pkg::KEY_ADD)
                     || (key == kfc_pkg::KEY_SUB) || (key == kfc_pkg::KEY_DIV);
    assign press_edge = pressed && !press_reg;

    assign hi_ext = {{(VALUE_WIDTH-31){1'b0}}, upper_reg};
    assign lo_ext = {{(VALUE_WIDTH-32){lower_reg[31]}}, lower_reg};

    // shared signed compare
    always_comb
    begin
        cmp_a = first_reg;
        cmp_b = hi_ext;
        case (seq_reg)
            kfc_pkg::SEQ_CHK_HI:
            begin
                cmp_a = hi_ext;
                cmp_b = arith_result;
            end
            kfc_pkg::SEQ_CHK_LO:
            begin
                cmp_a = arith_result;
                cmp_b = lo_ext;
            end
            kfc_pkg::SEQ_WCHK_SECOND:
            begin
                cmp_a = second_reg;
                cmp_b = hi_ext;
            end
            default:
            begin
                cmp_a = first_reg;
                cmp_b = hi_ext;
            end
        endcase
    end

    assign cmp_lt = $signed(cmp_a) < $signed(cmp_b);

    // key state transition for the tick on the input
    always_comb
    begin
        trans_state = ctl_reg;
        trans_last  = last_reg;
        chain       = 1'b0;
        case (ctl_reg)
            kfc_pkg::CTL_INIT:
            begin
                trans_state = kfc_pkg::CTL_CLEAR;
            end
            kfc_pkg::CTL_CLEAR:
            begin
                if (pressed && is_dig)
                begin
                    trans_state = kfc_pkg::CTL_ENTRY1;
                end
            end
            kfc_pkg::CTL_ENTRY1, kfc_pkg::CTL_OPER, kfc_pkg::CTL_ENTRY2,
            kfc_pkg::CTL_SHOW:
            begin
                trans_last  = ctl_reg;
                trans_state = kfc_pkg::CTL_WAIT;
            end
            kfc_pkg::CTL_EVAL:
            begin
                trans_state = kfc_pkg::CTL_SHOW;
            end
            default:
            begin
                if (pressed && key == kfc_pkg::KEY_CLEAR)
                begin
                    trans_state = kfc_pkg::CTL_CLEAR;
                end
                else if (err_reg != kfc_pkg::ERR_NONE)
                begin
                    trans_state = kfc_pkg::CTL_SHOW;
                end
                else if (press_edge && is_dig && last_reg == kfc_pkg::CTL_ENTRY1)
                begin
                    trans_state = kfc_pkg::CTL_ENTRY1;
                end
                else if (press_edge && is_dig && last_reg == kfc_pkg::CTL_ENTRY2)
                begin
                    trans_state = kfc_pkg::CTL_ENTRY2;
                end
                else if (press_edge && is_op && (last_reg == kfc_pkg::CTL_ENTRY1
                         || last_reg == kfc_pkg::CTL_OPER))
                begin
                    trans_state = kfc_pkg::CTL_OPER;
                end
                else if (press_edge && is_op && last_reg == kfc_pkg::CTL_SHOW)
                begin
                    // result carried into the next operation
                    chain       = 1'b1;
                    trans_state = kfc_pkg::CTL_OPER;
                end
                else if (press_edge && key == kfc_pkg::KEY_EQ
                         && last_reg == kfc_pkg::CTL_ENTRY2)
                begin
                    trans_state = kfc_pkg::CTL_EVAL;
                end
                else if (press_edge && is_dig && (last_reg == kfc_pkg::CTL_SHOW
                         || last_reg == kfc_pkg::CTL_OPER))
                begin
                    trans_state = kfc_pkg::CTL_ENTRY2;
                end
            end
        endcase
    end

    assign arith_a = (trans_state == kfc_pkg::CTL_ENTRY2) ? second_reg : first_reg;

    // sequencer
    always_comb
    begin
        ctl_next        = ctl_reg;
        last_next       = last_reg;
        seq_next        = seq_reg;
        err_next        = err_reg;
        press_next      = press_reg;
        first_next      = first_reg;
        second_next     = second_reg;
        answer_next     = answer_reg;
        oper_next       = oper_reg;
        pend_kind_next  = pend_kind_reg;
        pend_value_next = pend_value_reg;
        pend_oper_next  = pend_oper_reg;
        arith_req.start = 1'b0;
        arith_req.op    = kfc_pkg::ARITH_MAC10;
        arith_req.digit = key[3:0];
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_kind_next   = out_kind_reg;
        out_value_next  = out_value_reg;
        out_oper_next   = out_oper_reg;

        case (seq_reg)
            kfc_pkg::SEQ_IDLE:
            begin
                if (in_accept)
                begin
                    ctl_next   = trans_state;
                    last_next  = trans_last;
                    press_next = pressed;
                    if (chain)
                    begin
                        first_next  = answer_reg;
                        second_next = '0;
                        answer_next = '0;
                    end
                    case (trans_state)
                        kfc_pkg::CTL_CLEAR:
                        begin
                            first_next      = '0;
                            second_next     = '0;
                            answer_next     = '0;
                            oper_next       = '0;
                            err_next        = kfc_pkg::ERR_NONE;
                            pend_kind_next  = kfc_pkg::KIND_NUMBER;
                            pend_value_next = '0;
                            pend_oper_next  = '0;
                            seq_next        = kfc_pkg::SEQ_EMIT;
                        end
                        kfc_pkg::CTL_ENTRY1, kfc_pkg::CTL_ENTRY2:
                        begin
                            arith_req.start = 1'b1;
                            arith_req.op    = kfc_pkg::ARITH_MAC10;
                            seq_next        = kfc_pkg::SEQ_ARITH;
                        end
                        kfc_pkg::CTL_OPER:
                        begin
                            oper_next       = key;
                            pend_kind_next  = kfc_pkg::KIND_OPER;
                            pend_value_next = '0;
                            pend_oper_next  = key;
                            seq_next        = kfc_pkg::SEQ_EMIT;
                        end
                        kfc_pkg::CTL_EVAL:
                        begin
                            case (oper_reg)
                                kfc_pkg::KEY_ADD:
                                begin
                                    arith_req.start = 1'b1;
                                    arith_req.op    = kfc_pkg::ARITH_ADD;
                                    seq_next        = kfc_pkg::SEQ_ARITH;
                                end
                                kfc_pkg::KEY_SUB:
                                begin
                                    arith_req.start = 1'b1;
                                    arith_req.op    = kfc_pkg::ARITH_SUB;
                                    seq_next        = kfc_pkg::SEQ_ARITH;
                                end
                                kfc_pkg::KEY_MUL:
                                begin
                                    arith_req.start = 1'b1;
                                    arith_req.op    = kfc_pkg::ARITH_MUL;
                                    seq_next        = kfc_pkg::SEQ_ARITH;
                                end
                                kfc_pkg::KEY_DIV:
                                begin
                                    if (second_reg == '0)
                                    begin
                                        err_next = kfc_pkg::ERR_DIV0;
                                    end
                                    else
                                    begin
                                        arith_req.start = 1'b1;
                                        arith_req.op    = kfc_pkg::ARITH_DIV;
                                        seq_next        = kfc_pkg::SEQ_ARITH;
                                    end
                                end
                                default:
                                begin
                                    seq_next = kfc_pkg::SEQ_IDLE;
                                end
                            endcase
                        end
                        kfc_pkg::CTL_SHOW:
                        begin
                            pend_value_next = '0;
                            pend_oper_next  = '0;
                            case (err_reg)
                                kfc_pkg::ERR_UNDER: pend_kind_next = kfc_pkg::KIND_UNDER;
                                kfc_pkg::ERR_OVER:  pend_kind_next = kfc_pkg::KIND_OVER;
                                kfc_pkg::ERR_DIV0:  pend_kind_next = kfc_pkg::KIND_DIV0;
                                default:
                                begin
                                    pend_kind_next  = kfc_pkg::KIND_NUMBER;
                                    pend_value_next = answer_reg[SW-1:0];
                                end
                            endcase
                            seq_next = kfc_pkg::SEQ_EMIT;
                        end
                        kfc_pkg::CTL_WAIT:
                        begin
                            seq_next = kfc_pkg::SEQ_WCHK_FIRST;
                        end
                        default:
                        begin
                            seq_next = kfc_pkg::SEQ_IDLE;
                        end
                    endcase
                end
            end
            kfc_pkg::SEQ_ARITH:
            begin
                if (arith_done)
                begin
                    case (ctl_reg)
                        kfc_pkg::CTL_ENTRY1:
                        begin
                            first_next      = arith_result;
                            pend_kind_next  = kfc_pkg::KIND_NUMBER;
                            pend_value_next = arith_result[SW-1:0];
                            pend_oper_next  = '0;
                            seq_next        = kfc_pkg::SEQ_EMIT;
                        end
                        kfc_pkg::CTL_ENTRY2:
                        begin
                            second_next     = arith_result;
                            pend_kind_next  = kfc_pkg::KIND_NUMBER;
                            pend_value_next = arith_result[SW-1:0];
                            pend_oper_next  = '0;
                            seq_next        = kfc_pkg::SEQ_EMIT;
                        end
                        kfc_pkg::CTL_EVAL:
                        begin
                            if (oper_reg == kfc_pkg::KEY_SUB)
                            begin
                                seq_next = kfc_pkg::SEQ_CHK_LO;
                            end
                            else
                            begin
                                seq_next = kfc_pkg::SEQ_CHK_HI;
                            end
                        end
                        default:
                        begin
                            seq_next = kfc_pkg::SEQ_IDLE;
                        end
                    endcase
                end
            end
            kfc_pkg::SEQ_CHK_HI:
            begin
                if (cmp_lt)
                begin
                    err_next = kfc_pkg::ERR_OVER;
                    seq_next = kfc_pkg::SEQ_IDLE;
                end
                else if (oper_reg == kfc_pkg::KEY_MUL)
                begin
                    seq_next = kfc_pkg::SEQ_CHK_LO;
                end
                else
                begin
                    answer_next = arith_result;
                    seq_next    = kfc_pkg::SEQ_IDLE;
                end
            end
            kfc_pkg::SEQ_CHK_LO:
            begin
                if (cmp_lt)
                begin
                    err_next = kfc_pkg::ERR_UNDER;
                end
                else
                begin
                    answer_next = arith_result;
                end
                seq_next = kfc_pkg::SEQ_IDLE;
            end
            kfc_pkg::SEQ_WCHK_FIRST:
            begin
                if (!cmp_lt)
                begin
                    err_next = kfc_pkg::ERR_OVER;
                    seq_next = kfc_pkg::SEQ_IDLE;
                end
                else
                begin
                    seq_next = kfc_pkg::SEQ_WCHK_SECOND;
                end
            end
            kfc_pkg::SEQ_WCHK_SECOND:
            begin
                if (!cmp_lt)
                begin
                    err_next = kfc_pkg::ERR_OVER;
                end
                seq_next = kfc_pkg::SEQ_IDLE;
            end
            kfc_pkg::SEQ_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = pend_kind_reg;
                    out_value_next = pend_value_reg;
                    out_oper_next  = pend_oper_reg;
                    seq_next       = kfc_pkg::SEQ_IDLE;
                end
            end
            default:
            begin
                seq_next = kfc_pkg::SEQ_IDLE;
            end
        endcase
    end

    kfc_arith #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (arith_req),
        .a      (arith_a),
        .b      (second_reg),
        .done   (arith_done),
        .result (arith_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg       <= kfc_pkg::CTL_INIT;
            last_reg      <= kfc_pkg::CTL_INIT;
            seq_reg       <= kfc_pkg::SEQ_IDLE;
            err_reg       <= kfc_pkg::ERR_NONE;
            press_reg     <= 1'b0;
            first_reg     <= '0;
            second_reg    <= '0;
            answer_reg    <= '0;
            oper_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ctl_reg       <= ctl_next;
            last_reg      <= last_next;
            seq_reg       <= seq_next;
            err_reg       <= err_next;
            press_reg     <= press_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            answer_reg    <= answer_next;
            oper_reg      <= oper_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_kind_reg  <= pend_kind_next;
        pend_value_reg <= pend_value_next;
        pend_oper_reg  <= pend_oper_next;
        out_kind_reg   <= out_kind_next;
        out_value_reg  <= out_value_next;
        out_oper_reg   <= out_oper_next;
    end

    // limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= kfc_pkg::UPPER_RESET;
            lower_reg <= kfc_pkg::LOWER_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kfc_pkg::CFG_UPPER_LIMIT: upper_reg <= cfg_data[30:0];
                kfc_pkg::CFG_LOWER_LIMIT: lower_reg <= cfg_data;
                default:                  upper_reg <= upper_reg;
            endcase
        end
    end

    assign s_axis_tready = (seq_reg == kfc_pkg::SEQ_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {4'b0000, out_oper_reg, out_value_reg};

    `KFC_ASSERT(a_done_only_in_arith, arith_done |-> (seq_reg == kfc_pkg::SEQ_ARITH), "arith done outside arith wait")
    `KFC_ASSERT(a_accept_leaves_init, in_accept |=> (ctl_reg != kfc_pkg::CTL_INIT), "key state still in start state after a tick")
    `KFC_ASSERT(a_oper_beat_no_value, (m_axis_tvalid && (m_axis_tuser == kfc_pkg::KIND_OPER)) |-> (m_axis_tdata[35:0] == '0), "operator beat carries a number")

endmodule
